[sv/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge out of reset
`define BMX_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the clock after the antecedent
`define BMX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/bmx_pkg.sv]
// package: constants, register codes and shared types of the bitmap blit expander
package bmx_pkg;

	localparam int SCREEN_W = 320;
	localparam int SCREEN_H = 240;

	localparam int ROW_PK = SCREEN_W / 2;
	localparam int ROW_WD = SCREEN_W * 2;

	localparam int BYTE_W  = 8;
	localparam int COL_W   = 6;
	localparam int ROW_W   = 8;
	localparam int ADDR_W  = 18;
	localparam int COLOR_W = 16;
	localparam int X_W     = 12;
	localparam int Y_W     = 11;
	localparam int PIX_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [COLOR_W-1:0] COLOR4_MASK = 16'h000F;
	localparam logic [PIX_W-1:0]   PIX_LAST    = 3'd7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X   = 3'd0,
		REG_ORIGIN_Y   = 3'd1,
		REG_WIDTH      = 3'd2,
		REG_HEIGHT     = 3'd3,
		REG_FG_COLOR   = 3'd4,
		REG_BG_COLOR   = 3'd5,
		REG_PIXEL_MODE = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [9:0]         origin_x;
		logic [9:0]         origin_y;
		logic [8:0]         width_pixels;
		logic [7:0]         height_rows;
		logic [COLOR_W-1:0] fg_color;
		logic [COLOR_W-1:0] bg_color;
		logic               pixel_mode;
	} cfg_t;

	typedef struct packed {
		logic [COL_W-1:0] byte_column;
		logic [ROW_W-1:0] row_index;
		logic             last_col;
		logic             last_row;
	} cursor_t;

endpackage

[sv/bmx_if.sv]
// channel interfaces: bitmap byte in, pixel write out
interface bitmap_if import bmx_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] bitmap_byte;

	modport source (output valid, output bitmap_byte, input ready);
	modport sink (input valid, input bitmap_byte, output ready);
endinterface

interface pixel_if import bmx_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               write_enable;
	logic [ADDR_W-1:0]  byte_address;
	logic [COLOR_W-1:0] pixel_value;
	logic               high_nibble;
	logic               last_of_byte;
	logic               image_done;

	modport source (output valid, output write_enable, output byte_address,
		output pixel_value, output high_nibble, output last_of_byte,
		output image_done, input ready);
	modport sink (input valid, input write_enable, input byte_address,
		input pixel_value, input high_nibble, input last_of_byte,
		input image_done, output ready);
endinterface

[sv/bmx_cursor.sv]
// byte column and row counters of the bitmap, with end-of-row and end-of-image flags
module bmx_cursor import bmx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    advance,
	output cursor_t cursor
);

	logic [COL_W-1:0] byte_column_q;
	logic [ROW_W-1:0] row_index_q;
	logic [9:0]       width_sum;
	logic [6:0]       bpr_raw;
	logic [6:0]       bpr;
	logic [ROW_W-1:0] rows;
	logic             last_col;
	logic             last_row;

	always_comb begin
		width_sum = 10'(cfg.width_pixels) + 10'd7;
		bpr_raw   = width_sum[9:3];
		bpr       = (bpr_raw == 7'd0) ? 7'd1 : bpr_raw;
		rows      = (cfg.height_rows == 8'd0) ? 8'd1 : cfg.height_rows;
		last_col  = {1'b0, byte_column_q} >= (bpr - 7'd1);
		last_row  = row_index_q >= (rows - 8'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_column_q <= '0;
			row_index_q   <= '0;
		end else if (advance) begin
			if (last_col) begin
				byte_column_q <= '0;
				row_index_q   <= last_row ? '0 : row_index_q + 8'd1;
			end else begin
				byte_column_q <= byte_column_q + 6'd1;
			end
		end
	end

	assign cursor = '{byte_column: byte_column_q, row_index: row_index_q,
		last_col: last_col, last_row: last_row};

endmodule

[sv/bmx_expand.sv]
// byte holding stage, pixel counter and pixel write result register
module bmx_expand import bmx_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  cursor_t           cursor,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	pixel_if.source           pix
);

	logic                     hold_valid_s1;
	logic [BYTE_W-1:0]        byte_s1;
	logic signed [X_W-1:0]    xbase_s1;
	logic                     row_on_s1;
	logic [ADDR_W-1:0]        row_pk_s1;
	logic [ADDR_W-1:0]        row_wd_s1;
	logic                     done_s1;
	logic [PIX_W-1:0]         pix_idx_q;

	logic                     out_valid_s2;
	logic                     we_s2;
	logic [ADDR_W-1:0]        addr_s2;
	logic [COLOR_W-1:0]       color_s2;
	logic                     hi_s2;
	logic                     last_s2;
	logic                     done_s2;

	logic                     accept;
	logic                     out_load;
	logic                     pix_last;
	logic signed [X_W-1:0]    xbase_d;
	logic signed [Y_W-1:0]    ry;
	logic [9:0]               uy;
	logic                     row_on_d;
	logic signed [X_W-1:0]    rx;
	logic [10:0]              ux;
	logic                     on;
	logic [COLOR_W-1:0]       color;
	logic [ADDR_W-1:0]        addr;

	// next item enters as the eighth pixel of the held byte leaves
	assign out_load = hold_valid_s1 && (!out_valid_s2 || pix.ready);
	assign pix_last = pix_idx_q == PIX_LAST;
	assign in_ready = !hold_valid_s1 || (out_load && pix_last);
	assign accept   = in_valid && in_ready;

	// per-byte geometry
	always_comb begin
		xbase_d  = $signed({{2{cfg.origin_x[9]}}, cfg.origin_x})
			+ $signed({3'b000, cursor.byte_column, 3'b000}) + 12'sd8;
		ry       = $signed({cfg.origin_y[9], cfg.origin_y})
			+ $signed({3'b000, cursor.row_index});
		uy       = ry[9:0];
		row_on_d = !ry[Y_W-1] && ({1'b0, uy} < 11'(SCREEN_H));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_s1 <= 1'b0;
		end else if (accept) begin
			hold_valid_s1 <= 1'b1;
		end else if (out_load && pix_last) begin
			hold_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1   <= in_byte;
			xbase_s1  <= xbase_d;
			row_on_s1 <= row_on_d;
			row_pk_s1 <= ADDR_W'({8'b0, uy} * 18'(ROW_PK));
			row_wd_s1 <= ADDR_W'({8'b0, uy} * 18'(ROW_WD));
			done_s1   <= cursor.last_col && cursor.last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_idx_q <= '0;
		end else if (out_load) begin
			pix_idx_q <= pix_idx_q + 3'd1;
		end
	end

	// one pixel of the held byte
	always_comb begin
		rx    = xbase_s1 - $signed({9'b0, pix_idx_q});
		ux    = rx[10:0];
		on    = row_on_s1 && !rx[X_W-1] && (ux < 11'(SCREEN_W));
		color = byte_s1[pix_idx_q] ? cfg.fg_color : cfg.bg_color;
		if (!cfg.pixel_mode) begin
			color = color & COLOR4_MASK;
		end
		if (!on) begin
			addr = '0;
		end else if (cfg.pixel_mode) begin
			addr = row_wd_s1 + ADDR_W'({ux, 1'b0});
		end else begin
			addr = row_pk_s1 + ADDR_W'(ux[10:1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_load) begin
			out_valid_s2 <= 1'b1;
		end else if (pix.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			we_s2    <= on;
			addr_s2  <= addr;
			color_s2 <= color;
			hi_s2    <= on && !cfg.pixel_mode && !ux[0];
			last_s2  <= pix_last;
			done_s2  <= pix_last && done_s1;
		end
	end

	assign pix.valid        = out_valid_s2;
	assign pix.write_enable = we_s2;
	assign pix.byte_address = addr_s2;
	assign pix.pixel_value  = color_s2;
	assign pix.high_nibble  = hi_s2;
	assign pix.last_of_byte = last_s2;
	assign pix.image_done   = done_s2;

endmodule

[sv/mono_bitmap_blit_expander.sv]
// top level: configuration registers, bitmap cursor and pixel expansion
// Each bitmap byte transferred in yields eight pixel write transfers out, bit 0
// first, one per cycle while the output side does not stall, through a single
// result register. The first pixel write passes through the byte holding stage
// and then the result register; the next byte is taken in the cycle its
// predecessor's eighth pixel enters the result register.
// Configuration writes take effect at once and must only be made while idle.
module mono_bitmap_blit_expander import bmx_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bitmap_if.sink                bitmap,
	pixel_if.source               pixel
);

	cfg_t    cfg_q;
	cursor_t cursor;
	logic    in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{origin_x: 10'd0, origin_y: 10'd0, width_pixels: 9'd8,
				height_rows: 8'd1, fg_color: 16'd15, bg_color: 16'd0,
				pixel_mode: 1'b0};
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ORIGIN_X:   cfg_q.origin_x     <= cfg_data[9:0];
				REG_ORIGIN_Y:   cfg_q.origin_y     <= cfg_data[9:0];
				REG_WIDTH:      cfg_q.width_pixels <= cfg_data[8:0];
				REG_HEIGHT:     cfg_q.height_rows  <= cfg_data[7:0];
				REG_FG_COLOR:   cfg_q.fg_color     <= cfg_data;
				REG_BG_COLOR:   cfg_q.bg_color     <= cfg_data;
				REG_PIXEL_MODE: cfg_q.pixel_mode   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	bmx_cursor u_cursor (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.advance (bitmap.valid && in_ready),
		.cursor  (cursor)
	);

	bmx_expand u_expand (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cursor   (cursor),
		.in_valid (bitmap.valid),
		.in_ready (in_ready),
		.in_byte  (bitmap.bitmap_byte),
		.pix      (pixel)
	);

	assign bitmap.ready = in_ready;

endmodule

[sv/bmx_checker.sv]
// port-level checker of the bitmap blit expander, bound to the top level
`include "assert_macros.svh"

module bmx_checker import bmx_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               write_enable,
	input logic [ADDR_W-1:0]  byte_address,
	input logic [COLOR_W-1:0] pixel_value,
	input logic               high_nibble,
	input logic               last_of_byte,
	input logic               image_done
);

	`BMX_ASSERT(a_done_on_last, clk, arst_n, !(out_valid && image_done) || last_of_byte, "image end not on last pixel of a byte")
	`BMX_ASSERT(a_nibble_on_screen, clk, arst_n, !(out_valid && high_nibble) || write_enable, "nibble select on off-screen pixel")
	`BMX_ASSERT(a_offscreen_addr, clk, arst_n, !(out_valid && !write_enable) || (byte_address == '0), "off-screen pixel with non-zero address")
	`BMX_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(byte_address) && $stable(pixel_value) && $stable(last_of_byte), "stalled pixel write changed")

endmodule

bind mono_bitmap_blit_expander bmx_checker u_bmx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (pixel.valid),
	.out_ready    (pixel.ready),
	.write_enable (pixel.write_enable),
	.byte_address (pixel.byte_address),
	.pixel_value  (pixel.pixel_value),
	.high_nibble  (pixel.high_nibble),
	.last_of_byte (pixel.last_of_byte),
	.image_done   (pixel.image_done)
);
